// ===== rtl/epm_pkg.sv =====
// ----------------------------------------------------------------------------
// ECN percentage marker package
// Shared constants, register indexes and the stage record of the cell chain.
// ----------------------------------------------------------------------------
package epm_pkg;

  localparam int unsigned KeyWidth  = 32;
  localparam int unsigned PctWidth  = 7;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned InDataW   = 208;
  localparam int unsigned OutDataW  = 32;

  localparam logic [PctWidth-1:0] PctFull   = 7'd100;
  localparam logic [PctWidth-1:0] PctReset  = 7'd25;
  localparam logic [7:0]          ProtoTcp  = 8'd6;
  localparam logic [7:0]          ProtoUdp  = 8'd17;

  // Register indexes of the configuration channel.
  localparam logic [CfgAddrW-1:0] RegEcnEnable = 3'd0;
  localparam logic [CfgAddrW-1:0] RegAffinity  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegPctCe     = 3'd2;
  localparam logic [CfgAddrW-1:0] RegPctEct1   = 3'd3;
  localparam logic [CfgAddrW-1:0] RegPctEct0   = 3'd4;

  // ECN codes.
  localparam logic [1:0] CodeNotEct = 2'd0;
  localparam logic [1:0] CodeEct1   = 2'd1;
  localparam logic [1:0] CodeEct0   = 2'd2;
  localparam logic [1:0] CodeCe     = 2'd3;

  // Divisors of the three share tests, all in the range 1 to 100 when used.
  typedef struct packed {
    logic [PctWidth-1:0] d1;
    logic [PctWidth-1:0] d2;
    logic [PctWidth-1:0] d3;
  } epm_div_t;

  // One item as it moves along the chain.
  typedef struct packed {
    logic                valid;
    logic [KeyWidth-1:0] key;
    logic [PctWidth-1:0] r1;
    logic [PctWidth-1:0] r2;
    logic [PctWidth-1:0] r3;
    logic                is_ipv6;
    logic                proto_hit;
    logic [7:0]          tos;
    logic [15:0]         hc;
  } epm_stage_t;

endpackage

// ===== rtl/epm_mod_cell.sv =====
// ----------------------------------------------------------------------------
// ECN marker remainder cell
// Takes one key bit into three running remainders and hands the item on.
// ----------------------------------------------------------------------------
module epm_mod_cell import epm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  epm_div_t   div_i,
  input  epm_stage_t stage_i,
  output epm_stage_t stage_o
);

  logic       bit_in;
  epm_stage_t next;
  epm_stage_t stage_q;

  // One restoring step: shift in the key bit and subtract the divisor once.
  function automatic logic [PctWidth-1:0] mod_step(logic [PctWidth-1:0] r, logic b,
                                                   logic [PctWidth-1:0] d);
    logic [PctWidth:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[PctWidth-1:0];
  endfunction

  always_comb begin
    bit_in   = stage_i.key[KeyWidth-1];
    next     = stage_i;
    next.key = {stage_i.key[KeyWidth-2:0], 1'b0};
    next.r1  = mod_step(stage_i.r1, bit_in, div_i.d1);
    next.r2  = mod_step(stage_i.r2, bit_in, div_i.d2);
    next.r3  = mod_step(stage_i.r3, bit_in, div_i.d3);
  end

  // Only the valid bit is cleared at reset; the payload follows it along.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q.valid <= 1'b0;
    end else if (advance_i) begin
      stage_q <= next;
    end
  end

  assign stage_o = stage_q;

endmodule

// ===== rtl/ecn_percentage_marker_unit.sv =====
// ----------------------------------------------------------------------------
// ECN percentage marker
// Chooses an ECN code per packet header and rewrites the ECN bits.
// ----------------------------------------------------------------------------
// Usage: header summaries enter on the s_axis channel, one beat per packet;
// s_axis_tuser carries is_ipv6 and s_axis_tdata the remaining fields. Each
// beat yields exactly one result beat on m_axis, in order. The key is reduced
// modulo the three share divisors by a chain of 32 cells, one key bit per
// cell, ahead of the output register. One beat is accepted every cycle unless
// m_axis stalls. Registers are written over the cfg channel, which is always
// ready; the user must write them only while no packet is in flight (not
// enforced by the block). Reset clears all valid bits and loads the register
// defaults: rewriting off, port keying, all three percentages 25. When the
// receiver holds m_axis_tready low with a result waiting, the whole chain
// halts and s_axis_tready drops until the result is taken; nothing is lost.
// ----------------------------------------------------------------------------
module ecn_percentage_marker_unit import epm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Config write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [PctWidth-1:0] cfg_data_i,
  // Input stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: protocol[7:0], src_port[23:8], ip_src_addr[55:24], ip6_src_w0[87:56],
  // ip6_src_w1[119:88], ip6_src_w2[151:120], ip6_src_w3[183:152],
  // tos_in[191:184], hdr_checksum_in[207:192]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: is_ipv6[0]
  input  logic                s_axis_tuser,
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: ecn_code[1:0], tos_out[9:2], hdr_checksum_out[25:10], zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  // tuser: rewritten[0]
  output logic                m_axis_tuser
);

  localparam int unsigned NumCells = KeyWidth;

  logic                ecn_enable_q;
  logic                affinity_q;
  logic [PctWidth-1:0] pct_ce_q;
  logic [PctWidth-1:0] pct_ect1_q;
  logic [PctWidth-1:0] pct_ect0_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecn_enable_q <= 1'b0;
      affinity_q   <= 1'b0;
      pct_ce_q     <= PctReset;
      pct_ect1_q   <= PctReset;
      pct_ect0_q   <= PctReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        RegEcnEnable: ecn_enable_q <= cfg_data_i[0];
        RegAffinity:  affinity_q   <= cfg_data_i[0];
        RegPctCe:     pct_ce_q     <= cfg_data_i;
        RegPctEct1:   pct_ect1_q   <= cfg_data_i;
        RegPctEct0:   pct_ect0_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Divisors as signed quantities; a test with a divisor of zero or less is off.
  logic signed [8:0] div2_s;
  logic signed [8:0] div3_s;
  logic              div2_ok;
  logic              div3_ok;
  epm_div_t          div;

  assign div2_s  = $signed({2'b00, PctFull}) - $signed({2'b00, pct_ce_q});
  assign div3_s  = div2_s - $signed({2'b00, pct_ect1_q});
  assign div2_ok = (div2_s > 9'sd0);
  assign div3_ok = (div3_s > 9'sd0);
  assign div     = '{d1: PctFull, d2: div2_s[PctWidth-1:0], d3: div3_s[PctWidth-1:0]};

  // The chain moves whenever the output register is free or being emptied.
  logic advance;
  logic out_valid_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  // Input beat unpacked and keyed.
  logic [7:0]          in_proto;
  logic [15:0]         in_port;
  logic [KeyWidth-1:0] in_a4;
  logic [KeyWidth-1:0] in_a6;
  epm_stage_t          head;

  assign in_proto = s_axis_tdata[7:0];
  assign in_port  = s_axis_tdata[23:8];
  assign in_a4    = s_axis_tdata[55:24];
  assign in_a6    = s_axis_tdata[87:56] ^ s_axis_tdata[119:88] ^
                    s_axis_tdata[151:120] ^ s_axis_tdata[183:152];

  always_comb begin
    head.valid     = s_axis_tvalid;
    if (!affinity_q) begin
      head.key = {16'h0000, in_port};
    end else if (s_axis_tuser) begin
      head.key = in_a6;
    end else begin
      head.key = in_a4;
    end
    head.r1        = '0;
    head.r2        = '0;
    head.r3        = '0;
    head.is_ipv6   = s_axis_tuser;
    head.proto_hit = (in_proto == ProtoTcp) || (in_proto == ProtoUdp);
    head.tos       = s_axis_tdata[191:184];
    head.hc        = s_axis_tdata[207:192];
  end

  // Chain of remainder cells, one key bit each.
  epm_stage_t chain [NumCells+1];

  assign chain[0] = head;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    epm_mod_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .div_i     (div),
      .stage_i   (chain[g]),
      .stage_o   (chain[g+1])
    );
  end

  // Code choice and rewrite at the tail of the chain.
  epm_stage_t  tail;
  logic [1:0]  code;
  logic        do_rw;
  logic [7:0]  tos_new;
  logic [17:0] csum;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] hc_new;

  assign tail = chain[NumCells];

  always_comb begin
    if (!tail.proto_hit) begin
      code = CodeNotEct;
    end else if (pct_ce_q == PctFull) begin
      code = CodeCe;
    end else if ((pct_ce_q != '0) && (tail.r1 < pct_ce_q)) begin
      code = CodeCe;
    end else if ((pct_ect1_q != '0) && div2_ok && (tail.r2 < pct_ect1_q)) begin
      code = CodeEct1;
    end else if ((pct_ect0_q != '0) && div3_ok && (tail.r3 < pct_ect0_q)) begin
      code = CodeEct0;
    end else begin
      code = CodeNotEct;
    end
    do_rw   = ecn_enable_q && (code != CodeNotEct);
    tos_new = {tail.tos[7:2], code};
    csum    = {2'b00, ~tail.hc} + {2'b00, 8'hFF, ~tail.tos} + {10'h000, tos_new};
    fold1   = {1'b0, csum[15:0]} + {15'h0000, csum[17:16]};
    fold2   = fold1[15:0] + {15'h0000, fold1[16]};
    if (do_rw) begin
      hc_new = tail.is_ipv6 ? tail.hc : ~fold2;
    end else begin
      hc_new = tail.hc;
    end
  end

  // Output register.
  logic [1:0]  code_q;
  logic [7:0]  tos_q;
  logic [15:0] hc_q;
  logic        rw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= tail.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      code_q <= code;
      tos_q  <= do_rw ? tos_new : tail.tos;
      hc_q   <= hc_new;
      rw_q   <= do_rw;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, hc_q, tos_q, code_q};
  assign m_axis_tuser  = rw_q;

endmodule

// ===== dv/epm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECN marker result checker
// Watches the config, input and result channels of the marker, predicts the
// result of every accepted header beat and compares it field by field.
// ----------------------------------------------------------------------------
module epm_checker import epm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [PctWidth-1:0] cfg_data_i,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [InDataW-1:0]  s_data_i,
  input  logic                s_user_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [OutDataW-1:0] m_data_i,
  input  logic                m_user_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [1:0]  code;
    logic [7:0]  tos;
    logic [15:0] hc;
    logic        rewritten;
  } mark_t;

  logic          enable_q;
  logic          by_addr_q;
  logic [6:0]    ce_q, ect1_q, ect0_q;
  mark_t         marks_q[$];

  // Share test: a divisor of zero or less never matches.
  function automatic logic share_hit(logic [31:0] key, int div, logic [6:0] pct);
    if (pct == 0 || div <= 0) return 1'b0;
    return (key % div) < pct;
  endfunction

  function automatic mark_t predict_mark(logic v6, logic [InDataW-1:0] d);
    logic [7:0]  proto;
    logic [31:0] key;
    logic [16:0] sum;
    logic [7:0]  tos;
    logic [15:0] hc;
    mark_t       m;
    proto = d[7:0];
    tos   = d[191:184];
    hc    = d[207:192];
    m.code = CodeNotEct;
    m.tos = tos;
    m.hc = hc;
    m.rewritten = 1'b0;
    if (proto == ProtoTcp || proto == ProtoUdp) begin
      if (!by_addr_q) key = {16'd0, d[23:8]};
      else if (v6) key = d[87:56] ^ d[119:88] ^ d[151:120] ^ d[183:152];
      else key = d[55:24];
      if (ce_q == PctFull) m.code = CodeCe;
      else if (share_hit(key, 100, ce_q)) m.code = CodeCe;
      else if (share_hit(key, 100 - int'(ce_q), ect1_q)) m.code = CodeEct1;
      else if (share_hit(key, 100 - int'(ce_q) - int'(ect1_q), ect0_q)) m.code = CodeEct0;
      if (enable_q && m.code != CodeNotEct) begin
        m.tos = {tos[7:2], m.code};
        if (!v6) begin
          // Incremental checksum update with end-around carry.
          sum = {1'b0, ~hc} + {1'b0, ~{8'd0, tos}};
          sum = {1'b0, sum[15:0]} + {16'd0, sum[16]};
          sum = {1'b0, sum[15:0]} + {9'd0, m.tos};
          sum = {1'b0, sum[15:0]} + {16'd0, sum[16]};
          m.hc = ~sum[15:0];
        end
        m.rewritten = 1'b1;
      end
    end
    return m;
  endfunction

  assign pending_o = marks_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    mark_t want;
    mark_t got;
    if (!rst_ni) begin
      enable_q <= 1'b0;
      by_addr_q <= 1'b0;
      ce_q <= PctReset;
      ect1_q <= PctReset;
      ect0_q <= PctReset;
      mismatches_o <= 0;
      marks_q.delete();
    end else begin
      // Register writes.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          RegEcnEnable: enable_q <= cfg_data_i[0];
          RegAffinity:  by_addr_q <= cfg_data_i[0];
          RegPctCe:     ce_q <= cfg_data_i;
          RegPctEct1:   ect1_q <= cfg_data_i;
          RegPctEct0:   ect0_q <= cfg_data_i;
          default: ;
        endcase
      end
      // Predict each accepted header beat.
      if (s_valid_i && s_ready_i) marks_q.push_back(predict_mark(s_user_i, s_data_i));
      // Compare each result beat with the oldest prediction.
      if (m_valid_i && m_ready_i) begin
        got.code = m_data_i[1:0];
        got.tos = m_data_i[9:2];
        got.hc = m_data_i[25:10];
        got.rewritten = m_user_i;
        if (marks_q.size() == 0) begin
          if (mismatches_o < 10) $display("unexpected result beat %h", m_data_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = marks_q.pop_front();
          if (want !== got || m_data_i[31:26] !== 6'd0) begin
            if (mismatches_o < 10)
              $display("mismatch: code %0d/%0d tos %h/%h hc %h/%h rw %b/%b (exp/act)",
                       want.code, got.code, want.tos, got.tos, want.hc, got.hc,
                       want.rewritten, got.rewritten);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb_ecn_percentage_marker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECN marker testbench
// Drives directed and random header beats through several register settings
// with random stalls on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_ecn_percentage_marker_unit;
  import epm_pkg::*;

  localparam int Latency = 40;
  localparam int StallLimit = 5000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [PctWidth-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  int                  mismatches;
  int                  pending;
  int                  idle_cycles = 0;
  bit                  calm = 1'b0;
  bit                  hold_off = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ecn_percentage_marker_unit dut (.*);

  epm_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_addr_i, .cfg_data_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .s_user_i(s_axis_tuser), .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_i(m_axis_tdata), .m_user_i(m_axis_tuser), .mismatches_o(mismatches),
    .pending_o(pending));

  // Receiver: random stalls, none while calm, held low during a hold-off.
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 10);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [PctWidth-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(bit en, bit addr, int ce, int e1, int e0);
    write_reg(RegEcnEnable, {6'd0, en});
    write_reg(RegAffinity, {6'd0, addr});
    write_reg(RegPctCe, PctWidth'(ce));
    write_reg(RegPctEct1, PctWidth'(e1));
    write_reg(RegPctEct0, PctWidth'(e0));
  endtask

  // One header beat; sender gaps at random unless calm.
  task automatic send_header(bit v6, logic [7:0] proto, logic [15:0] port,
                             logic [31:0] a4, logic [127:0] a6, logic [7:0] tos,
                             logic [15:0] hc);
    while (!calm && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= v6;
    s_axis_tdata <= {hc, tos, a6, a4, port, proto};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random(int n);
    logic [7:0] proto;
    logic [127:0] a6;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: proto = 8'($urandom_range(255));
        1, 2, 3, 4: proto = ProtoTcp;
        default: proto = ProtoUdp;
      endcase
      a6 = {$urandom, $urandom, $urandom, $urandom};
      send_header(1'($urandom_range(1)), proto, 16'($urandom_range(65535)), $urandom, a6,
                  8'($urandom_range(255)), 16'($urandom_range(65535)));
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats under reset defaults, then with rewriting on.
    send_header(1'b0, ProtoTcp, 16'd0, 32'd0, '0, 8'h00, 16'h0000);
    send_header(1'b0, ProtoUdp, 16'hFFFF, '1, '1, 8'hFF, 16'hFFFF);
    drain();
    set_regs(1, 0, 25, 25, 25);
    for (int p = 0; p < 8; p++)
      send_header(p[0], ProtoTcp, 16'(p * 13), 32'd0, '0, 8'(8'hA5 + p),
                  16'(16'h1234 * p));
    send_header(1'b0, 8'd1, 16'd3, 32'd0, '0, 8'h03, 16'hBEEF);
    send_header(1'b0, ProtoUdp, 16'd0, 32'd0, '0, 8'hFF, 16'h0000);
    send_header(1'b0, ProtoUdp, 16'd0, 32'd0, '0, 8'h03, 16'hFFFF);
    drain();
    // Address keying, IPv4 and IPv6, percentages at the extremes.
    set_regs(1, 1, 100, 0, 0);
    send_header(1'b0, ProtoTcp, 16'd7, 32'h8000_0001, '0, 8'h00, 16'h0001);
    send_header(1'b1, ProtoTcp, 16'd7, 32'd0, {32'h1, 32'h2, 32'h4, 32'h8}, 8'hFC, 16'h55AA);
    drain();
    set_regs(1, 1, 0, 100, 0);
    send_header(1'b0, ProtoUdp, 16'd0, 32'd99, '0, 8'h12, 16'h4321);
    send_header(1'b1, ProtoUdp, 16'd0, 32'd0, {96'd0, 32'hFFFF_FFFF}, 8'h12, 16'h4321);
    drain();
    // A sum past one hundred gives a negative divisor.
    set_regs(1, 0, 70, 60, 50);
    send_header(1'b0, ProtoTcp, 16'd69, 32'd0, '0, 8'h00, 16'h0);
    send_header(1'b0, ProtoTcp, 16'd70, 32'd0, '0, 8'h00, 16'h0);
    drain();

    // Random phases across register settings.
    set_regs(1, 0, 25, 25, 25);
    send_random(300);
    // Long receiver hold-off while the sender keeps offering beats.
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_random(150);
    join
    drain();
    set_regs(1, 1, 10, 30, 40);
    send_random(300);
    drain();
    set_regs(0, 1, 127, 127, 127);
    send_random(150);
    drain();
    set_regs(1, 0, 0, 0, 100);
    calm = 1'b1;
    send_random(250);
    calm = 1'b0;
    drain();
    set_regs(1, 1, 50, 50, 127);
    send_random(300);
    drain();
    set_regs(1, 1'($urandom_range(1)), $urandom_range(100), $urandom_range(100),
             $urandom_range(100));
    send_random(250);
    drain();

    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
